>>> sv/sdst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdst_pkg
// Shared types and fixed field widths for the shuffle and deal stack.
// ----------------------------------------------------------------------------
package sdst_pkg;

    localparam int RAND_BITS = 31;
    localparam int REQ_BITS  = 7;
    localparam int OP_BITS   = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PUSH    = 2'd1,
        OP_SHUFFLE = 2'd2,
        OP_DEAL    = 2'd3
    } t_op;

endpackage
`default_nettype wire

>>> sv/shuffle_deal_stack_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shuffle_deal_stack_top
// Element stack with clear, push, in-place shuffle step and deal from the top.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  command   start / busy          i_op i_element_in i_restart i_random_word
//                                  i_deal_request
//  result    o_valid (one cycle)   o_element_out o_element_valid o_last
//                                  o_undealt o_fill_count o_shuffle_done
//                                  o_rejected
//
//  clear, push and trivial shuffle steps: result in the cycle after start
//  shuffle swap: result after states S_MOD (31-step remainder), S_RDJ and S_WRJ
//  deal: one element per cycle, each read from the top entry through the registered RAM read
//  reset clears state, fill count, shuffle position and valid only; the store is undefined until pushed
//  results cannot be stalled; busy stays high until the last beat is issued
// ----------------------------------------------------------------------------
module shuffle_deal_stack_top
    import sdst_pkg::*;
#(
    parameter int CAPACITY     = 128,
    parameter int ELEMENT_BITS = 8,
    parameter int MAX_DEAL     = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [OP_BITS-1:0]      i_op,
    input  wire logic [ELEMENT_BITS-1:0] i_element_in,
    input  wire logic                    i_restart,
    input  wire logic [RAND_BITS-1:0]    i_random_word,
    input  wire logic [REQ_BITS-1:0]     i_deal_request,
    output logic                         o_valid,
    output logic [ELEMENT_BITS-1:0]      o_element_out,
    output logic                         o_element_valid,
    output logic                         o_last,
    output logic [REQ_BITS-1:0]          o_undealt,
    output logic [$clog2(CAPACITY+1)-1:0] o_fill_count,
    output logic                         o_shuffle_done,
    output logic                         o_rejected
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_RDJ  = 5'b00100,
        S_WRJ  = 5'b01000,
        S_DEAL = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [PW-1:0]           r_pos, n_pos;
    logic [PW-1:0]           r_j, n_j;
    logic [ELEMENT_BITS-1:0] r_tmp, n_tmp;
    logic [REQ_BITS-1:0]     r_want, n_want;
    logic [REQ_BITS-1:0]     r_req, n_req;
    logic [REQ_BITS-1:0]     r_n, n_n;
    logic                    r_valid, n_valid;
    logic                    r_ev, n_ev;
    logic                    r_last, n_last;
    logic [REQ_BITS-1:0]     r_undealt, n_undealt;
    logic                    r_rej, n_rej;

    logic                    w_wr_en, w_rd_en;
    logic [PW-1:0]           w_wr_addr, w_rd_addr;
    logic [ELEMENT_BITS-1:0] w_wr_data, w_rd_data;
    logic                    w_mod_start, w_mod_done;
    logic [CW-1:0]           w_mod_rem;
    logic [PW-1:0]           w_p;
    logic [REQ_BITS-1:0]     w_want;
    logic [REQ_BITS-1:0]     w_n1;
    logic [CW-1:0]           w_cnt1;
    logic                    w_fin;

    sdst_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sdst_mod #(
        .DIV_BITS (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_random_word),
        .i_divisor  (CW'(w_p) + CW'(1)),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_comb begin
        if (i_restart) begin
            w_p = (r_count != '0) ? PW'(r_count - 1'b1) : '0;
        end else begin
            w_p = r_pos;
        end
        w_want = (i_deal_request > REQ_BITS'(MAX_DEAL)) ? REQ_BITS'(MAX_DEAL)
                                                        : i_deal_request;
        w_n1   = r_n + 1'b1;
        w_cnt1 = r_count - 1'b1;
        w_fin  = (w_n1 == r_want) || (w_cnt1 == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_j         = r_j;
        n_tmp       = r_tmp;
        n_want      = r_want;
        n_req       = r_req;
        n_n         = r_n;
        n_valid     = 1'b0;
        n_ev        = 1'b0;
        n_last      = 1'b1;
        n_undealt   = '0;
        n_rej       = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[PW-1:0];
        w_wr_data   = i_element_in;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_p;
        w_mod_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                            n_valid = 1'b1;
                        end
                        OP_PUSH: begin
                            n_valid = 1'b1;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_rej = 1'b1;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_SHUFFLE: begin
                            if (w_p == '0) begin
                                n_pos   = '0;
                                n_valid = 1'b1;
                            end else if (CW'(w_p) >= r_count) begin
                                n_pos   = '0;
                                n_valid = 1'b1;
                            end else begin
                                n_pos       = w_p;
                                w_rd_en     = 1'b1;
                                w_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                        OP_DEAL: begin
                            if (w_want == '0 || r_count == '0) begin
                                n_valid   = 1'b1;
                                n_undealt = i_deal_request;
                            end else begin
                                n_want  = w_want;
                                n_req   = i_deal_request;
                                n_n     = '0;
                                n_state = S_DEAL;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_tmp     = w_rd_data;
                    n_j       = w_mod_rem[PW-1:0];
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_mod_rem[PW-1:0];
                    n_state   = S_RDJ;
                end
            end
            S_RDJ: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = w_rd_data;
                n_state   = S_WRJ;
            end
            S_WRJ: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j;
                w_wr_data = r_tmp;
                n_pos     = r_pos - 1'b1;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            S_DEAL: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_cnt1[PW-1:0];
                n_count   = w_cnt1;
                n_n       = w_n1;
                n_valid   = 1'b1;
                n_ev      = 1'b1;
                n_last    = w_fin;
                n_undealt = w_fin ? (r_req - w_n1) : '0;
                if (w_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_tmp     <= n_tmp;
        r_want    <= n_want;
        r_req     <= n_req;
        r_n       <= n_n;
        r_ev      <= n_ev;
        r_last    <= n_last;
        r_undealt <= n_undealt;
        r_rej     <= n_rej;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_element_out   = (r_valid && r_ev) ? w_rd_data : '0;
    assign o_element_valid = r_valid && r_ev;
    assign o_last          = r_valid && r_last;
    assign o_undealt       = r_valid ? r_undealt : '0;
    assign o_fill_count    = r_count;
    assign o_shuffle_done  = (r_pos == '0);
    assign o_rejected      = r_valid && r_rej;

    a_ev_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_element_valid |-> o_valid)
        else $error("element beat without result strobe");

    a_mid_deal_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final deal beat while idle");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rejected |-> (o_fill_count == CW'(CAPACITY)))
        else $error("push rejected while stack not full");

    a_undealt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_undealt != '0) |-> o_last)
        else $error("undealt count on a non-final beat");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (CW'(r_pos) < r_count))
        else $error("shuffle position beyond fill count");

endmodule
`default_nettype wire

>>> sv/sdst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdst_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> sv/sdst_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdst_mod
// Bit-serial restoring remainder of the random word by a narrow divisor.
// ----------------------------------------------------------------------------
module sdst_mod
    import sdst_pkg::*;
#(
    parameter int DIV_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [RAND_BITS-1:0] i_dividend,
    input  wire logic [DIV_BITS-1:0]  i_divisor,
    output logic                      o_done,
    output logic      [DIV_BITS-1:0]  o_rem
);

    localparam int CNT_W = $clog2(RAND_BITS);

    logic                 r_run;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [RAND_BITS-1:0] r_dvd;
    logic [DIV_BITS-1:0]  r_dvs;
    logic [DIV_BITS-1:0]  r_rem;
    logic [DIV_BITS:0]    w_trial;
    logic [DIV_BITS:0]    w_diff;
    logic [DIV_BITS-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[RAND_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_diff[DIV_BITS-1:0];
        end else begin
            n_rem = w_trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(RAND_BITS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[RAND_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire
